// File: hdl/lfkj_pkg.sv
// Package for the leg forward kinematics and Jacobian block.
// Holds the CORDIC arctangent table and shared constants; no dependencies.
package lfkj_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int LEN_BITS     = 20;
    localparam int TRIG_BITS    = 33;
    localparam logic signed [TRIG_BITS-1:0] CORDIC_X0 = 33'sd652032874;

    typedef enum logic [2:0] {
        KIND_POS  = 3'd0,
        KIND_ERR  = 3'd1,
        KIND_COL0 = 3'd2,
        KIND_COL1 = 3'd3,
        KIND_COL2 = 3'd4,
        KIND_COL3 = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        REG_LEN_L     = 2'd0,
        REG_LEN_HIP   = 2'd1,
        REG_LEN_SPINE = 2'd2
    } reg_index_t;

    function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:  atan_turn = 34'sd536870912;
            5'd1:  atan_turn = 34'sd316933406;
            5'd2:  atan_turn = 34'sd167458907;
            5'd3:  atan_turn = 34'sd85004756;
            5'd4:  atan_turn = 34'sd42667331;
            5'd5:  atan_turn = 34'sd21354465;
            5'd6:  atan_turn = 34'sd10679838;
            5'd7:  atan_turn = 34'sd5340245;
            5'd8:  atan_turn = 34'sd2670163;
            5'd9:  atan_turn = 34'sd1335087;
            5'd10: atan_turn = 34'sd667544;
            5'd11: atan_turn = 34'sd333772;
            5'd12: atan_turn = 34'sd166886;
            5'd13: atan_turn = 34'sd83443;
            5'd14: atan_turn = 34'sd41722;
            5'd15: atan_turn = 34'sd20861;
            5'd16: atan_turn = 34'sd10430;
            5'd17: atan_turn = 34'sd5215;
            5'd18: atan_turn = 34'sd2608;
            5'd19: atan_turn = 34'sd1304;
            5'd20: atan_turn = 34'sd652;
            5'd21: atan_turn = 34'sd326;
            5'd22: atan_turn = 34'sd163;
            5'd23: atan_turn = 34'sd81;
            default: atan_turn = 34'sd0;
        endcase
    endfunction

endpackage

// File: hdl/lfkj_cordic.sv
// Pipelined rotation-mode CORDIC: a fold stage, then one micro-rotation per stage, 25 stages.
// Depends on lfkj_pkg for the arctangent table.
module lfkj_cordic (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic [31:0]                               phase,
    output logic signed [lfkj_pkg::TRIG_BITS-1:0]     sin_q30,
    output logic signed [lfkj_pkg::TRIG_BITS-1:0]     cos_q30
);
    localparam int N = lfkj_pkg::CORDIC_STEPS;
    localparam int W = lfkj_pkg::TRIG_BITS;

    logic signed [W-1:0] x_reg [N+1];
    logic signed [W-1:0] y_reg [N+1];
    logic signed [33:0]  z_reg [N+1];
    logic                flip_reg [N+1];

    // Stage 0 folds the left half-plane onto the right.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= lfkj_pkg::CORDIC_X0;
            y_reg[0]    <= '0;
            flip_reg[0] <= phase[31] ^ phase[30];
            z_reg[0]    <= 34'(signed'(phase ^ {(phase[31] ^ phase[30]), 31'd0}));
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][33])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - lfkj_pkg::atan_turn(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + lfkj_pkg::atan_turn(5'(i));
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    assign cos_q30 = flip_reg[N] ? -x_reg[N] : x_reg[N];
    assign sin_q30 = flip_reg[N] ? -y_reg[N] : y_reg[N];

    logic unused_rst;
    assign unused_rst = rst_n;
endmodule

// File: hdl/leg_forward_kinematics_jacobian.sv
// Leg forward kinematics and Jacobian, top level.
// Throughput: one result beat per cycle while out_ready is high. Each input item
// yields six result beats; the six-beat output serializer holds one item, and
// the pipeline stalls while it is full and the head of the pipe is valid.
// Reset (rst_n, asynchronous, active low) clears valid bits, the beat counter
// and the three length registers.
module leg_forward_kinematics_jacobian #(
    parameter int ANGLE_BITS = 16,
    parameter int COORD_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [19:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [ANGLE_BITS-1:0]  spine_angle,
    input  logic signed [ANGLE_BITS-1:0]  abduction_angle,
    input  logic signed [ANGLE_BITS-1:0]  hip_angle,
    input  logic signed [ANGLE_BITS-1:0]  knee_angle,
    input  logic signed [COORD_BITS-1:0]  ref_x,
    input  logic signed [COORD_BITS-1:0]  ref_y,
    input  logic signed [COORD_BITS-1:0]  ref_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    kind,
    output logic signed [COORD_BITS-1:0]  x_value,
    output logic signed [COORD_BITS-1:0]  y_value,
    output logic signed [COORD_BITS-1:0]  z_value,
    output logic                          overflow,
    output logic                          last
);
    localparam int TW   = lfkj_pkg::TRIG_BITS;
    localparam int AW   = 56;   // wide enough for every intermediate sum
    localparam int CSTG = lfkj_pkg::CORDIC_STEPS + 1;
    localparam int LAT  = CSTG + 6;

    // Configuration registers.
    logic [19:0] len_l_reg, len_hip_reg, len_spine_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_l_reg <= '0; len_hip_reg <= '0; len_spine_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lfkj_pkg::REG_LEN_L:     len_l_reg     <= cfg_data;
                lfkj_pkg::REG_LEN_HIP:   len_hip_reg   <= cfg_data;
                lfkj_pkg::REG_LEN_SPINE: len_spine_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances whenever the output serializer is free. The
    // serializer holds one item and drains it over six beats; the pipe stalls
    // as a whole while the holding stage is busy and the head is valid.
    logic              en;
    logic [LAT-1:0]    vld_reg;
    logic              hold_full_reg;
    logic [2:0]        beat_reg;
    logic              hold_take;
    assign hold_take = vld_reg[LAT-1] && (!hold_full_reg ||
                       (out_ready && beat_reg == 3'(lfkj_pkg::KIND_COL3)));
    assign en        = !vld_reg[LAT-1] || hold_take;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // Angle phases.
    function automatic logic [31:0] to_phase(input logic [ANGLE_BITS-1:0] a);
        to_phase = {a, {(32-ANGLE_BITS){1'b0}}};
    endfunction

    logic [ANGLE_BITS-1:0] sum23;
    assign sum23 = hip_angle + knee_angle;

    logic signed [TW-1:0] s0, c0, s1, c1, s2, c2, s3, c3;
    lfkj_cordic u_cor0 (.clk, .rst_n, .en, .phase(to_phase(spine_angle)),
                        .sin_q30(s0), .cos_q30(c0));
    lfkj_cordic u_cor1 (.clk, .rst_n, .en, .phase(to_phase(abduction_angle)),
                        .sin_q30(s1), .cos_q30(c1));
    lfkj_cordic u_cor2 (.clk, .rst_n, .en, .phase(to_phase(hip_angle)),
                        .sin_q30(s2), .cos_q30(c2));
    lfkj_cordic u_cor3 (.clk, .rst_n, .en, .phase(to_phase(sum23)),
                        .sin_q30(s3), .cos_q30(c3));

    // Reference delay line alongside the CORDIC pipes.
    logic signed [COORD_BITS-1:0] rx_reg [LAT], ry_reg [LAT], rz_reg [LAT];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0] <= ref_x; ry_reg[0] <= ref_y; rz_reg[0] <= ref_z;
            for (int i = 1; i < LAT; i++)
            begin
                rx_reg[i] <= rx_reg[i-1]; ry_reg[i] <= ry_reg[i-1];
                rz_reg[i] <= rz_reg[i-1];
            end
        end
    end

    // Q16 times Q30 product, rounded half up. The Q16 operand is always a
    // length or a small sum of length products, so 32 bits hold it easily.
    function automatic logic signed [AW-1:0] mulq(input logic signed [AW-1:0] a,
                                                  input logic signed [TW-1:0] t);
        logic signed [31:0] a_n;
        logic signed [64:0] p;
        a_n = a[31:0];
        p = 65'(a_n) * 65'(t) + (65'sd1 <<< 29);
        mulq = AW'(p >>> 30);
    endfunction

    // Length times a sum of two trig values, rounded half up.
    function automatic logic signed [AW-1:0] mul_len(input logic [19:0] l,
                                                     input logic signed [TW:0] t);
        logic signed [20:0]   l_s;
        logic signed [AW-1:0] p;
        l_s = {1'b0, l};
        p = AW'(l_s) * AW'(t) + (AW'(64'sd1) <<< 29);
        mul_len = p >>> 30;
    endfunction

    function automatic logic signed [AW-1:0] ulen(input logic [19:0] v);
        ulen = AW'({1'b0, v});
    endfunction

    // Stage A: sums of trig terms, hold trig values.
    logic signed [TW:0]   sS_reg, sC_reg;
    logic signed [TW-1:0] a_s0, a_c0, a_s1, a_c1, a_s3, a_c3;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sS_reg <= (TW+1)'(s2) + (TW+1)'(s3);
            sC_reg <= (TW+1)'(c2) + (TW+1)'(c3);
            a_s0 <= s0; a_c0 <= c0; a_s1 <= s1; a_c1 <= c1; a_s3 <= s3; a_c3 <= c3;
        end
    end

    // Stage B: length products. The hip-plus-knee terms use the full trig
    // sums so that the rounding matches a single product.
    logic signed [AW-1:0] ls3_reg, lc3_reg, lsf_reg, lcf_reg;
    logic signed [TW-1:0] b_s0, b_c0, b_s1, b_c1;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lsf_reg <= mul_len(len_l_reg, sS_reg);
            lcf_reg <= mul_len(len_l_reg, sC_reg);
            ls3_reg <= mulq(ulen(len_l_reg), a_s3);
            lc3_reg <= mulq(ulen(len_l_reg), a_c3);
            b_s0 <= a_s0; b_c0 <= a_c0; b_s1 <= a_s1; b_c1 <= a_c1;
        end
    end

    // Stage C: products with abduction terms.
    logic signed [AW-1:0] ls_c1, ls_s1, lh_c1, lh_s1, lc_s1, lc_c1, lc3_s1, lc3_c1;
    logic signed [AW-1:0] ls_s0, ls3_s0, px_pre, lsp_c0, lsp_s0;
    logic signed [TW-1:0] c_s0, c_c0;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ls_c1  <= mulq(lsf_reg, b_c1);
            ls_s1  <= mulq(lsf_reg, b_s1);
            lh_c1  <= mulq(ulen(len_hip_reg), b_c1);
            lh_s1  <= mulq(ulen(len_hip_reg), b_s1);
            lc_s1  <= mulq(lcf_reg, b_s1);
            lc_c1  <= mulq(lcf_reg, b_c1);
            lc3_s1 <= mulq(lc3_reg, b_s1);
            lc3_c1 <= mulq(lc3_reg, b_c1);
            ls_s0  <= mulq(lsf_reg, b_s0);
            ls3_s0 <= mulq(ls3_reg, b_s0);
            px_pre <= -lcf_reg - ulen(len_spine_reg);
            lsp_c0 <= mulq(ulen(len_spine_reg), b_c0);
            lsp_s0 <= mulq(ulen(len_spine_reg), b_s0);
            c_s0 <= b_s0; c_c0 <= b_c0;
        end
    end

    // Stage D: sums.
    logic signed [AW-1:0] d_a, d_py, d_j1y, d_j1z, d_px;
    logic signed [AW-1:0] d_lcc1, d_lc3c1, d_ls_s0, d_ls3_s0, d_lc_s1, d_lc3_s1;
    logic signed [AW-1:0] d_lsp_c0, d_lsp_s0;
    logic signed [TW-1:0] d_s0, d_c0;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_a    <= ls_c1 - lh_s1;
            d_py   <= lh_c1 + ls_s1;
            d_j1y  <= -lh_s1 + ls_c1;
            d_j1z  <= -ls_s1 - lh_c1;
            d_px   <= px_pre;
            d_lcc1 <= lc_c1; d_lc3c1 <= lc3_c1;
            d_ls_s0 <= ls_s0; d_ls3_s0 <= ls3_s0;
            d_lc_s1 <= lc_s1; d_lc3_s1 <= lc3_s1;
            d_lsp_c0 <= lsp_c0; d_lsp_s0 <= lsp_s0;
            d_s0 <= c_s0; d_c0 <= c_c0;
        end
    end

    // Stage E: products with the spine terms.
    logic signed [AW-1:0] e_px, e_ac0, e_as0, e_j1z, e_j2z, e_j3z;
    logic signed [AW-1:0] e_py, e_j1y, e_ls_s0, e_ls3_s0, e_lc_s1, e_lc3_s1;
    logic signed [AW-1:0] e_lsp_c0, e_lsp_s0;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_px  <= mulq(d_px, d_c0);
            e_ac0 <= mulq(d_a, d_c0);
            e_as0 <= mulq(d_a, d_s0);
            e_j1z <= mulq(d_j1z, d_c0);
            e_j2z <= mulq(d_lcc1, d_c0);
            e_j3z <= mulq(d_lc3c1, d_c0);
            e_py <= d_py; e_j1y <= d_j1y;
            e_ls_s0 <= d_ls_s0; e_ls3_s0 <= d_ls3_s0;
            e_lc_s1 <= d_lc_s1; e_lc3_s1 <= d_lc3_s1;
            e_lsp_c0 <= d_lsp_c0; e_lsp_s0 <= d_lsp_s0;
        end
    end

    // Stage F: final sums; result set registered.
    logic signed [AW-1:0] f_px, f_py, f_pz, f_j0z;
    logic signed [AW-1:0] f_j1y, f_j1z, f_j2x, f_j2y, f_j2z, f_j3x, f_j3y, f_j3z;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_px <= e_px; f_py <= e_py;
            f_pz <= e_ac0 + e_lsp_s0;
            f_j0z <= -e_as0 + e_lsp_c0;
            f_j1y <= e_j1y; f_j1z <= e_j1z;
            f_j2x <= e_ls_s0; f_j2y <= e_lc_s1; f_j2z <= e_j2z;
            f_j3x <= e_ls3_s0; f_j3y <= e_lc3_s1; f_j3z <= e_j3z;
        end
    end

    // Holding stage: the whole result set for one item, drained in six beats.
    logic signed [AW-1:0] h_reg [18];
    always_ff @(posedge clk)
    begin
        if (hold_take)
        begin
            h_reg[0] <= f_px;  h_reg[1] <= f_py;  h_reg[2] <= f_pz;
            h_reg[3] <= AW'(rx_reg[LAT-1]) - f_px;
            h_reg[4] <= AW'(ry_reg[LAT-1]) - f_py;
            h_reg[5] <= AW'(rz_reg[LAT-1]) - f_pz;
            h_reg[6] <= f_px;  h_reg[7] <= '0;    h_reg[8] <= f_j0z;
            h_reg[9] <= '0;    h_reg[10] <= f_j1y; h_reg[11] <= f_j1z;
            h_reg[12] <= f_j2x; h_reg[13] <= f_j2y; h_reg[14] <= f_j2z;
            h_reg[15] <= f_j3x; h_reg[16] <= f_j3y; h_reg[17] <= f_j3z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_full_reg <= 1'b0;
            beat_reg      <= 3'(lfkj_pkg::KIND_POS);
        end
        else if (hold_take)
        begin
            hold_full_reg <= 1'b1;
            beat_reg      <= 3'(lfkj_pkg::KIND_POS);
        end
        else if (hold_full_reg && out_ready)
        begin
            if (beat_reg == 3'(lfkj_pkg::KIND_COL3))
                hold_full_reg <= 1'b0;
            else
                beat_reg <= beat_reg + 3'd1;
        end
    end

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi, lo;
        hi = (AW'(1) <<< (COORD_BITS-1)) - AW'(1);
        lo = -hi - AW'(1);
        if (v > hi)      sat = COORD_BITS'(hi);
        else if (v < lo) sat = COORD_BITS'(lo);
        else             sat = COORD_BITS'(v);
    endfunction

    function automatic logic is_ovf(input logic signed [AW-1:0] v);
        is_ovf = (v != AW'(sat(v)));
    endfunction

    logic signed [AW-1:0] ox, oy, oz;
    always_comb
    begin
        case (beat_reg)
            3'd0: begin ox = h_reg[0];  oy = h_reg[1];  oz = h_reg[2];  end
            3'd1: begin ox = h_reg[3];  oy = h_reg[4];  oz = h_reg[5];  end
            3'd2: begin ox = h_reg[6];  oy = h_reg[7];  oz = h_reg[8];  end
            3'd3: begin ox = h_reg[9];  oy = h_reg[10]; oz = h_reg[11]; end
            3'd4: begin ox = h_reg[12]; oy = h_reg[13]; oz = h_reg[14]; end
            default: begin ox = h_reg[15]; oy = h_reg[16]; oz = h_reg[17]; end
        endcase
    end

    assign out_valid = hold_full_reg;
    assign kind      = beat_reg;
    assign x_value   = sat(ox);
    assign y_value   = sat(oy);
    assign z_value   = sat(oz);
    assign overflow  = is_ovf(ox) | is_ovf(oy) | is_ovf(oz);
    assign last      = (beat_reg == 3'(lfkj_pkg::KIND_COL3));
endmodule

// File: tb/sv/tb.sv
// Testbench for leg_forward_kinematics_jacobian: random and directed joint beats,
// checked against an in-file fixed-point kinematics predictor.
// Depends on hdl/lfkj_pkg.sv and hdl/leg_forward_kinematics_jacobian.sv.
`timescale 1ns / 1ps

module tb;

    localparam int ANG_W  = 16;
    localparam int CRD_W  = 32;
    // Extra wait after the owed beats have come, so that the pipeline drains.
    localparam int SETTLE = 48;
    // Cycles with no beat on either channel before the run is declared hung.
    localparam int HANG_LIMIT = 5000;

    localparam longint ATAN_STEP [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct {
        lfkj_pkg::kind_t   kind;
        logic [CRD_W-1:0]  x;
        logic [CRD_W-1:0]  y;
        logic [CRD_W-1:0]  z;
        logic              ovf;
        logic              last;
    } leg_result_t;

    // The scoreboard keeps its own copy of the three lengths and a queue of
    // the result beats that the accepted joint beats still owe.
    class leg_scoreboard;
        longint        len_l, len_hip, len_spine;
        leg_result_t   owed[$];
        int            errors;

        function new();
            len_l = 0;
            len_hip = 0;
            len_spine = 0;
            errors = 0;
        endfunction

        function void set_length(lfkj_pkg::reg_index_t idx, logic [19:0] val);
            case (idx)
                lfkj_pkg::REG_LEN_L:     len_l = longint'(val);
                lfkj_pkg::REG_LEN_HIP:   len_hip = longint'(val);
                lfkj_pkg::REG_LEN_SPINE: len_spine = longint'(val);
                default: ;
            endcase
        endfunction

        // Q16 times Q30 back to Q16, rounding half up.
        function longint mul_trig(longint a, longint t);
            return (a * t + (longint'(1) <<< 29)) >>> 30;
        endfunction

        function void sin_cos(logic [ANG_W-1:0] ang, output longint s, output longint c);
            logic [31:0] phase;
            longint      x, y, z, nx, ny;
            bit          flip;
            phase = {ang, {(32-ANG_W){1'b0}}};
            flip = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
            if (flip)
                phase = phase + 32'h8000_0000;
            x = 652032874;
            y = 0;
            z = longint'($signed(phase));
            for (int i = 0; i < 24; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z = z - ATAN_STEP[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z = z + ATAN_STEP[i];
                end
                x = nx;
                y = ny;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function logic [CRD_W-1:0] clamp(longint v, inout logic ovf);
            longint hi, lo;
            hi = (longint'(1) <<< (CRD_W-1)) - 1;
            lo = -hi - 1;
            if (v > hi)
            begin
                v = hi;
                ovf = 1'b1;
            end
            if (v < lo)
            begin
                v = lo;
                ovf = 1'b1;
            end
            return v[CRD_W-1:0];
        endfunction

        function void owe(lfkj_pkg::kind_t k, longint x, longint y, longint z);
            leg_result_t r;
            r.ovf = 1'b0;
            r.kind = k;
            r.x = clamp(x, r.ovf);
            r.y = clamp(y, r.ovf);
            r.z = clamp(z, r.ovf);
            r.last = (k == lfkj_pkg::KIND_COL3);
            owed.push_back(r);
        endfunction

        function void note_input(logic [ANG_W-1:0] q0, logic [ANG_W-1:0] q1,
                                 logic [ANG_W-1:0] q2, logic [ANG_W-1:0] q3,
                                 logic [CRD_W-1:0] rx, logic [CRD_W-1:0] ry,
                                 logic [CRD_W-1:0] rz);
            longint s0, c0, s1, c1, s2, c2, s23, c23;
            longint ls, lc, ls3, lc3, px, py, pz, a;
            logic [ANG_W-1:0] q23;
            q23 = q2 + q3;
            sin_cos(q0, s0, c0);
            sin_cos(q1, s1, c1);
            sin_cos(q2, s2, c2);
            sin_cos(q23, s23, c23);
            ls = mul_trig(len_l, s2 + s23);
            lc = mul_trig(len_l, c2 + c23);
            ls3 = mul_trig(len_l, s23);
            lc3 = mul_trig(len_l, c23);
            px = mul_trig(-lc - len_spine, c0);
            py = mul_trig(len_hip, c1) + mul_trig(ls, s1);
            a = mul_trig(ls, c1) - mul_trig(len_hip, s1);
            pz = mul_trig(a, c0) + mul_trig(len_spine, s0);
            owe(lfkj_pkg::KIND_POS, px, py, pz);
            owe(lfkj_pkg::KIND_ERR, longint'($signed(rx)) - px,
                longint'($signed(ry)) - py, longint'($signed(rz)) - pz);
            owe(lfkj_pkg::KIND_COL0, px, 0, -mul_trig(a, s0) + mul_trig(len_spine, c0));
            owe(lfkj_pkg::KIND_COL1, 0, -mul_trig(len_hip, s1) + mul_trig(ls, c1),
                mul_trig(-mul_trig(ls, s1) - mul_trig(len_hip, c1), c0));
            owe(lfkj_pkg::KIND_COL2, mul_trig(ls, s0), mul_trig(lc, s1),
                mul_trig(mul_trig(lc, c1), c0));
            owe(lfkj_pkg::KIND_COL3, mul_trig(ls3, s0), mul_trig(lc3, s1),
                mul_trig(mul_trig(lc3, c1), c0));
        endfunction

        function void check_result(logic [2:0] k, logic [CRD_W-1:0] x,
                                   logic [CRD_W-1:0] y, logic [CRD_W-1:0] z,
                                   logic ovf, logic lst);
            leg_result_t e;
            if (owed.size() == 0)
            begin
                $display("%0t: result beat kind %0d with nothing owed", $time, k);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (k !== e.kind || x !== e.x || y !== e.y || z !== e.z ||
                ovf !== e.ovf || lst !== e.last)
            begin
                $display("%0t: mismatch expected kind %0d x %h y %h z %h ovf %b last %b",
                         $time, e.kind, e.x, e.y, e.z, e.ovf, e.last);
                $display("%0t:          actual   kind %0d x %h y %h z %h ovf %b last %b",
                         $time, k, x, y, z, ovf, lst);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [19:0]      cfg_data;
    logic             in_valid;
    logic             in_ready;
    logic [ANG_W-1:0] spine_angle, abduction_angle, hip_angle, knee_angle;
    logic [CRD_W-1:0] ref_x, ref_y, ref_z;
    logic             out_valid;
    logic             out_ready;
    logic [2:0]       kind;
    logic [CRD_W-1:0] x_value, y_value, z_value;
    logic             overflow;
    logic             last;

    leg_scoreboard    board;
    int               burst_left;
    int               out_beats;
    int               quiet_cycles;

    leg_forward_kinematics_jacobian #(
        .ANGLE_BITS(ANG_W),
        .COORD_BITS(CRD_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .spine_angle(spine_angle),
        .abduction_angle(abduction_angle),
        .hip_angle(hip_angle),
        .knee_angle(knee_angle),
        .ref_x(ref_x),
        .ref_y(ref_y),
        .ref_z(ref_z),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .x_value(x_value),
        .y_value(y_value),
        .z_value(z_value),
        .overflow(overflow),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Every result beat is checked at the rising edge where it is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            board.check_result(kind, x_value, y_value, z_value, overflow, last);
            out_beats++;
        end
    end

    // The watchdog ends a run in which neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // The receiver changes its stall habit at random times: always
    // ready, a coin toss, or mostly stalled. Once, after some traffic, it
    // holds off for a long stretch so that the block backs up into its input.
    initial
    begin
        int  mode;
        int  mode_left;
        bit  held;
        mode = 0;
        mode_left = 0;
        held = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && out_beats >= 300)
            begin
                held = 1;
                out_ready = 1'b0;
                repeat (400) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
                0: out_ready = 1'b1;
                1: out_ready = 1'($urandom_range(0, 1));
                default: out_ready = ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Offers one joint beat. The sender works in bursts; between bursts it
    // drops valid for a random gap. Inside a burst valid stays high and only
    // the payload moves on to the next beat.
    task automatic send_joint(logic [ANG_W-1:0] q0, logic [ANG_W-1:0] q1,
                              logic [ANG_W-1:0] q2, logic [ANG_W-1:0] q3,
                              logic [CRD_W-1:0] rx, logic [CRD_W-1:0] ry,
                              logic [CRD_W-1:0] rz);
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        else
        begin
            @(negedge clk);
        end
        spine_angle = q0;
        abduction_angle = q1;
        hip_angle = q2;
        knee_angle = q3;
        ref_x = rx;
        ref_y = ry;
        ref_z = rz;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_input(q0, q1, q2, q3, rx, ry, rz);
        burst_left--;
    endtask

    // Lengths only change while the block is empty: valid is dropped, every
    // owed beat must have come, and the pipeline is given time to drain.
    task automatic set_lengths(logic [19:0] l, logic [19:0] lh, logic [19:0] ls);
        @(negedge clk);
        in_valid = 1'b0;
        burst_left = 0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = lfkj_pkg::REG_LEN_L;
        cfg_data = l;
        board.set_length(lfkj_pkg::REG_LEN_L, l);
        @(negedge clk);
        cfg_index = lfkj_pkg::REG_LEN_HIP;
        cfg_data = lh;
        board.set_length(lfkj_pkg::REG_LEN_HIP, lh);
        @(negedge clk);
        cfg_index = lfkj_pkg::REG_LEN_SPINE;
        cfg_data = ls;
        board.set_length(lfkj_pkg::REG_LEN_SPINE, ls);
        @(negedge clk);
        // Index three names no register; the write must change nothing.
        cfg_index = 2'd3;
        cfg_data = 20'($urandom);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [ANG_W-1:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h4000;
            3: return 16'hc000;
            default: return ANG_W'($urandom);
        endcase
    endfunction

    function automatic logic [CRD_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_joints(int count);
        for (int n = 0; n < count; n++)
            send_joint(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                       pick_coord(), pick_coord(), pick_coord());
    endtask

    initial
    begin
        logic [ANG_W-1:0] edge_ang [6];
        board = new();
        burst_left = 0;
        out_beats = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lfkj_pkg::REG_LEN_L;
        cfg_data = '0;
        in_valid = 1'b0;
        spine_angle = '0;
        abduction_angle = '0;
        hip_angle = '0;
        knee_angle = '0;
        ref_x = '0;
        ref_y = '0;
        ref_z = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset lengths of zero first: the position is zero, so the error
        // beat simply echoes the reference.
        send_joint(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h7fff_ffff,
                   32'h8000_0000, 32'h0000_0001);
        random_joints(20);

        // Longest links with references at the rails, so that the error can saturate.
        set_lengths(20'hfffff, 20'hfffff, 20'hfffff);
        edge_ang = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000, 16'hc000, 16'h0001};
        foreach (edge_ang[i])
            send_joint(edge_ang[i], edge_ang[5-i], edge_ang[i], edge_ang[(i+2)%6],
                       32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        // Hip plus knee wrapping past a half turn either way.
        send_joint(16'h1234, 16'hedcb, 16'h7fff, 16'h7fff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff);
        send_joint(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000);
        send_joint(16'hffff, 16'hffff, 16'hffff, 16'h0001, 32'hffff_ffff,
                   32'h0000_0000, 32'h0001_0000);
        random_joints(80);

        // A leg of plausible size.
        set_lengths(20'h04000, 20'h01800, 20'h0c000);
        random_joints(90);

        set_lengths(20'($urandom), 20'($urandom), 20'($urandom));
        random_joints(80);

        set_lengths(20'h00001, 20'h00000, 20'hfffff);
        random_joints(80);

        @(negedge clk);
        in_valid = 1'b0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
hdl/lfkj_pkg.sv
hdl/lfkj_cordic.sv
hdl/leg_forward_kinematics_jacobian.sv
tb/sv/tb.sv
